[design/tmhq_pkg.sv]
// Package: shared types, constants and helpers for the timer min-heap queue.
`timescale 1ns / 1ps
`default_nettype none
package tmhq_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ID_COUNT_DEF = 1024;
    localparam int MAX_RESULTS  = 64;

    localparam int FUNC_W = 3;
    localparam int ID_W   = 10;
    localparam int TMO_W  = 24;
    localparam int TIME_W = 32;
    localparam int WAIT_W = 24;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 3'd0,
        FUNC_ADJ   = 3'd1,
        FUNC_FIRE  = 3'd2,
        FUNC_TICK  = 3'd3,
        FUNC_CLEAR = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PENDING = 2'd1,
        ST_FULL        = 2'd2
    } stat_code_t;

    // What a push into the result buffer records
    typedef enum logic [2:0] {
        RES_OK,
        RES_NOT_PENDING,
        RES_FULL,
        RES_FIRED,
        RES_POP
    } res_kind_t;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_ACCEPT,
        OP_LOOKUP,
        OP_NEW,
        OP_SET,
        OP_RM_RD,
        OP_RM_LOAD,
        OP_DN_RD,
        OP_DN_STEP,
        OP_UP_RD,
        OP_UP_STEP,
        OP_PLACE,
        OP_PUSH,
        OP_TK_RD,
        OP_CLEAR,
        OP_SUM_RD,
        OP_SUM,
        OP_EMIT
    } op_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_DISP,
        S_RM,
        S_RM_LD,
        S_DN_RD,
        S_DN_ST,
        S_UP_RD,
        S_UP_ST,
        S_PLACE,
        S_TK,
        S_TK_CMP,
        S_TK_END,
        S_OKP,
        S_SUM_RD,
        S_SUM,
        S_EMIT
    } state_t;

    typedef struct packed {
        op_t       op;
        res_kind_t res;
        logic      root;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  id_ok;
        logic  pend;
        logic  full;
        logic  leaf;
        logic  dn_stop;
        logic  up_stop;
        logic  root;
        logic  moved;
        logic  tail;
        logic  size_zero;
        logic  cnt_full;
        logic  cnt_zero;
        logic  due;
        logic  last;
        logic  init_done;
    } dp_stat_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } node_t;

    typedef struct packed {
        logic [ID_W-1:0] fid;
        logic            fired;
        stat_code_t      status;
    } res_t;

    // Wrap-safe ordering: a expires before b
    function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage
`default_nettype wire

[design/tmhq_dp.sv]
// Datapath: heap memory, position map, result buffer and sift registers.
`timescale 1ns / 1ps
`default_nettype none
module tmhq_dp #(
    parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF,
    parameter int ID_COUNT = tmhq_pkg::ID_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire tmhq_pkg::cmd_t                cmd,
    input  wire logic [tmhq_pkg::FUNC_W-1:0]   func,
    input  wire logic [tmhq_pkg::ID_W-1:0]     id,
    input  wire logic [tmhq_pkg::TMO_W-1:0]    timeout_ms,
    input  wire logic [tmhq_pkg::TIME_W-1:0]   now_ms,
    output tmhq_pkg::dp_stat_t                 stat,
    output logic [tmhq_pkg::ID_W-1:0]          fired_id,
    output logic                               fired,
    output logic [tmhq_pkg::STAT_W-1:0]        status,
    output logic                               next_valid,
    output logic [tmhq_pkg::WAIT_W-1:0]        next_wait_ms,
    output logic [tmhq_pkg::CNT_W-1:0]         pending_count
);
    import tmhq_pkg::*;

    localparam int PW  = $clog2(CAPACITY);
    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int IW  = $clog2(ID_COUNT);
    localparam int RIW = $clog2(MAX_RESULTS);
    localparam int RCW = $clog2(MAX_RESULTS + 1);

    // Storage
    node_t          heap_mem [CAPACITY];
    logic [PW-1:0]  map_mem  [ID_COUNT];
    res_t           res_mem  [MAX_RESULTS];

    // Control registers
    logic [SW-1:0]  size_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [RCW-1:0] ecnt_reg;
    logic [IW-1:0]  init_reg;

    // Payload registers
    func_t             func_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] exp_reg;
    node_t             item_reg;
    logic [PW-1:0]     hole_reg;
    logic [PW-1:0]     pos_reg;
    logic              moved_reg;
    node_t             rda_reg;
    node_t             rdb_reg;
    logic [PW-1:0]     mrd_reg;
    res_t              frd_reg;
    logic              nv_reg;
    logic [WAIT_W-1:0] wait_reg;

    // Memory port controls
    logic          ha_en, hb_en, hw_en, mr_en, mw_en, fw_en, fr_en;
    logic [PW-1:0] ha_addr, hb_addr, hw_addr, mw_data;
    node_t         hw_data;
    logic [IW-1:0] mr_addr, mw_addr;
    logic [RIW-1:0] fr_addr;
    res_t          push_data;

    // Sift arithmetic
    logic [PW+1:0]     c_w, c1_w;
    logic              pick_b, dn_stop, up_stop;
    node_t             child;
    logic [PW-1:0]     child_idx, parent_idx;
    logic [TIME_W-1:0] d_root;

    always_comb
    begin
        c_w        = {1'b0, hole_reg, 1'b1};
        c1_w       = c_w + (PW+2)'(1);
        pick_b     = (c1_w < (PW+2)'(size_reg)) && earlier(rdb_reg.expiry, rda_reg.expiry);
        child      = pick_b ? rdb_reg : rda_reg;
        child_idx  = pick_b ? c1_w[PW-1:0] : c_w[PW-1:0];
        dn_stop    = earlier(item_reg.expiry, child.expiry);
        parent_idx = (hole_reg - PW'(1)) >> 1;
        up_stop    = earlier(rda_reg.expiry, item_reg.expiry);
        d_root     = rda_reg.expiry - now_reg;
    end

    // Status back to the controller
    always_comb
    begin
        stat.func      = func_reg;
        stat.id_ok     = 32'(id_reg) < 32'(ID_COUNT);
        stat.pend      = stat.id_ok && (SW'(pos_reg) < size_reg) && (rda_reg.id == id_reg);
        stat.full      = size_reg == SW'(CAPACITY);
        stat.leaf      = c_w >= (PW+2)'(size_reg);
        stat.dn_stop   = dn_stop;
        stat.up_stop   = up_stop;
        stat.root      = hole_reg == '0;
        stat.moved     = moved_reg;
        stat.tail      = SW'(hole_reg) < size_reg;
        stat.size_zero = size_reg == '0;
        stat.cnt_full  = rcnt_reg == RCW'(MAX_RESULTS);
        stat.cnt_zero  = rcnt_reg == '0;
        stat.due       = (d_root == '0) || d_root[TIME_W-1];
        stat.last      = ecnt_reg == (rcnt_reg - RCW'(1));
        stat.init_done = init_reg == IW'(ID_COUNT - 1);
    end

    // Result record for a push
    always_comb
    begin
        push_data = '{fid: '0, fired: 1'b0, status: ST_OK};
        case (cmd.res)
            RES_OK:          push_data = '{fid: '0, fired: 1'b0, status: ST_OK};
            RES_NOT_PENDING: push_data = '{fid: '0, fired: 1'b0, status: ST_NOT_PENDING};
            RES_FULL:        push_data = '{fid: '0, fired: 1'b0, status: ST_FULL};
            RES_FIRED:       push_data = '{fid: id_reg, fired: 1'b1, status: ST_OK};
            RES_POP:         push_data = '{fid: rda_reg.id, fired: 1'b1, status: ST_OK};
            default:         push_data = '{fid: '0, fired: 1'b0, status: ST_OK};
        endcase
    end

    // Memory port steering
    always_comb
    begin
        ha_en   = 1'b0;
        ha_addr = '0;
        hb_en   = 1'b0;
        hb_addr = '0;
        hw_en   = 1'b0;
        hw_addr = hole_reg;
        hw_data = item_reg;
        mw_en   = 1'b0;
        mw_addr = IW'(item_reg.id);
        mw_data = hole_reg;
        mr_en   = 1'b0;
        mr_addr = IW'(id);
        fw_en   = 1'b0;
        fr_en   = 1'b0;
        fr_addr = '0;
        case (cmd.op)
            OP_INIT:
            begin
                mw_en   = 1'b1;
                mw_addr = init_reg;
                mw_data = '0;
            end
            OP_ACCEPT:
            begin
                mr_en = 1'b1;
            end
            OP_LOOKUP:
            begin
                ha_en   = 1'b1;
                ha_addr = mrd_reg;
            end
            OP_RM_RD:
            begin
                ha_en   = 1'b1;
                ha_addr = PW'(size_reg - SW'(1));
            end
            OP_DN_RD:
            begin
                ha_en   = 1'b1;
                ha_addr = c_w[PW-1:0];
                hb_en   = 1'b1;
                hb_addr = c1_w[PW-1:0];
            end
            OP_DN_STEP:
            begin
                if (!dn_stop)
                begin
                    hw_en   = 1'b1;
                    hw_data = child;
                    mw_en   = 1'b1;
                    mw_addr = IW'(child.id);
                end
            end
            OP_UP_RD:
            begin
                ha_en   = 1'b1;
                ha_addr = parent_idx;
            end
            OP_UP_STEP:
            begin
                if (!up_stop)
                begin
                    hw_en   = 1'b1;
                    hw_data = rda_reg;
                    mw_en   = 1'b1;
                    mw_addr = IW'(rda_reg.id);
                end
            end
            OP_PLACE:
            begin
                hw_en = 1'b1;
                mw_en = 1'b1;
            end
            OP_PUSH:
            begin
                fw_en = 1'b1;
            end
            OP_TK_RD, OP_SUM_RD:
            begin
                ha_en = 1'b1;
            end
            OP_SUM:
            begin
                fr_en = 1'b1;
            end
            OP_EMIT:
            begin
                fr_en   = 1'b1;
                fr_addr = RIW'(ecnt_reg + RCW'(1));
            end
            default:
            begin
            end
        endcase
    end

    // Heap memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (hw_en)
            heap_mem[hw_addr] <= hw_data;
        if (ha_en)
            rda_reg <= heap_mem[ha_addr];
        if (hb_en)
            rdb_reg <= heap_mem[hb_addr];
    end

    // Position map memory
    always_ff @(posedge clk)
    begin
        if (mw_en)
            map_mem[mw_addr] <= mw_data;
        if (mr_en)
            mrd_reg <= map_mem[mr_addr];
    end

    // Result buffer memory
    always_ff @(posedge clk)
    begin
        if (fw_en)
            res_mem[RIW'(rcnt_reg)] <= push_data;
        if (fr_en)
            frd_reg <= res_mem[fr_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            rcnt_reg <= '0;
            ecnt_reg <= '0;
            init_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_INIT:   init_reg <= init_reg + IW'(1);
                OP_ACCEPT: rcnt_reg <= '0;
                OP_NEW:    size_reg <= size_reg + SW'(1);
                OP_RM_RD:  size_reg <= size_reg - SW'(1);
                OP_CLEAR:  size_reg <= '0;
                OP_PUSH:   rcnt_reg <= rcnt_reg + RCW'(1);
                OP_SUM:    ecnt_reg <= '0;
                OP_EMIT:   ecnt_reg <= ecnt_reg + RCW'(1);
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                func_reg <= func_t'(func);
                id_reg   <= id;
                now_reg  <= now_ms;
                exp_reg  <= now_ms + TIME_W'(timeout_ms);
            end
            OP_LOOKUP:
            begin
                pos_reg <= mrd_reg;
            end
            OP_NEW:
            begin
                hole_reg  <= PW'(size_reg);
                item_reg  <= '{id: id_reg, expiry: exp_reg};
                moved_reg <= 1'b0;
            end
            OP_SET:
            begin
                hole_reg  <= pos_reg;
                item_reg  <= '{id: id_reg, expiry: exp_reg};
                moved_reg <= 1'b0;
            end
            OP_RM_RD:
            begin
                hole_reg  <= cmd.root ? '0 : pos_reg;
                moved_reg <= 1'b0;
            end
            OP_RM_LOAD:
            begin
                item_reg <= rda_reg;
            end
            OP_DN_STEP:
            begin
                if (!dn_stop)
                begin
                    hole_reg  <= child_idx;
                    moved_reg <= 1'b1;
                end
            end
            OP_UP_STEP:
            begin
                if (!up_stop)
                    hole_reg <= parent_idx;
            end
            OP_SUM:
            begin
                nv_reg <= size_reg != '0;
                if (size_reg == '0 || d_root[TIME_W-1])
                    wait_reg <= '0;
                else if (d_root > TIME_W'(WAIT_MAX))
                    wait_reg <= WAIT_MAX;
                else
                    wait_reg <= d_root[WAIT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign fired_id      = frd_reg.fid;
    assign fired         = frd_reg.fired;
    assign status        = frd_reg.status;
    assign next_valid    = nv_reg;
    assign next_wait_ms  = wait_reg;
    assign pending_count = CNT_W'(size_reg);

endmodule
`default_nettype wire

[design/tmhq_ctrl.sv]
// Controller: sequences lookup, sift, tick and result delivery.
`timescale 1ns / 1ps
`default_nettype none
module tmhq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire tmhq_pkg::dp_stat_t stat,
    output tmhq_pkg::cmd_t          cmd,
    output logic                    busy,
    output logic                    valid,
    output logic                    last
);
    import tmhq_pkg::*;

    state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: OP_NONE, res: RES_OK, root: 1'b0};
        busy       = 1'b1;
        valid      = 1'b0;
        last       = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                cmd.op = OP_INIT;
                if (stat.init_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.op     = OP_LOOKUP;
                state_next = S_DISP;
            end
            S_DISP:
            begin
                case (stat.func)
                    FUNC_ADD:
                    begin
                        if (!stat.id_ok)
                        begin
                            cmd.op     = OP_PUSH;
                            cmd.res    = RES_NOT_PENDING;
                            state_next = S_SUM_RD;
                        end
                        else if (stat.pend)
                        begin
                            cmd.op     = OP_SET;
                            state_next = S_DN_RD;
                        end
                        else if (stat.full)
                        begin
                            cmd.op     = OP_PUSH;
                            cmd.res    = RES_FULL;
                            state_next = S_SUM_RD;
                        end
                        else
                        begin
                            cmd.op     = OP_NEW;
                            state_next = S_UP_RD;
                        end
                    end
                    FUNC_ADJ:
                    begin
                        if (!stat.pend)
                        begin
                            cmd.op     = OP_PUSH;
                            cmd.res    = RES_NOT_PENDING;
                            state_next = S_SUM_RD;
                        end
                        else
                        begin
                            cmd.op     = OP_SET;
                            state_next = S_DN_RD;
                        end
                    end
                    FUNC_FIRE:
                    begin
                        cmd.op = OP_PUSH;
                        if (!stat.pend)
                        begin
                            cmd.res    = RES_NOT_PENDING;
                            state_next = S_SUM_RD;
                        end
                        else
                        begin
                            cmd.res    = RES_FIRED;
                            state_next = S_RM;
                        end
                    end
                    FUNC_TICK:
                    begin
                        state_next = S_TK;
                    end
                    FUNC_CLEAR:
                    begin
                        cmd.op     = OP_CLEAR;
                        state_next = S_OKP;
                    end
                    default:
                    begin
                        state_next = S_OKP;
                    end
                endcase
            end
            // Remove: pull the last node into the hole
            S_RM:
            begin
                cmd.op     = OP_RM_RD;
                cmd.root   = stat.func == FUNC_TICK;
                state_next = S_RM_LD;
            end
            S_RM_LD:
            begin
                if (stat.tail)
                begin
                    cmd.op     = OP_RM_LOAD;
                    state_next = S_DN_RD;
                end
                else if (stat.func == FUNC_TICK)
                    state_next = S_TK;
                else
                    state_next = S_SUM_RD;
            end
            // Sift down, falling back to sift up when nothing moved
            S_DN_RD:
            begin
                if (stat.leaf)
                    state_next = stat.moved ? S_PLACE : S_UP_RD;
                else
                begin
                    cmd.op     = OP_DN_RD;
                    state_next = S_DN_ST;
                end
            end
            S_DN_ST:
            begin
                cmd.op = OP_DN_STEP;
                if (stat.dn_stop)
                    state_next = stat.moved ? S_PLACE : S_UP_RD;
                else
                    state_next = S_DN_RD;
            end
            S_UP_RD:
            begin
                if (stat.root)
                    state_next = S_PLACE;
                else
                begin
                    cmd.op     = OP_UP_RD;
                    state_next = S_UP_ST;
                end
            end
            S_UP_ST:
            begin
                cmd.op     = OP_UP_STEP;
                state_next = stat.up_stop ? S_PLACE : S_UP_RD;
            end
            S_PLACE:
            begin
                cmd.op = OP_PLACE;
                if (stat.func == FUNC_TICK)
                    state_next = S_TK;
                else if (stat.func == FUNC_FIRE)
                    state_next = S_SUM_RD;
                else
                    state_next = S_OKP;
            end
            // Tick: pop the root while it is due and the result buffer is not full
            S_TK:
            begin
                if (stat.size_zero || stat.cnt_full)
                    state_next = S_TK_END;
                else
                begin
                    cmd.op     = OP_TK_RD;
                    state_next = S_TK_CMP;
                end
            end
            S_TK_CMP:
            begin
                if (stat.due)
                begin
                    cmd.op     = OP_PUSH;
                    cmd.res    = RES_POP;
                    state_next = S_RM;
                end
                else
                    state_next = S_TK_END;
            end
            S_TK_END:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.op  = OP_PUSH;
                    cmd.res = RES_OK;
                end
                state_next = S_SUM_RD;
            end
            S_OKP:
            begin
                cmd.op     = OP_PUSH;
                cmd.res    = RES_OK;
                state_next = S_SUM_RD;
            end
            // Summary and delivery
            S_SUM_RD:
            begin
                cmd.op     = OP_SUM_RD;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op     = OP_SUM;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.op = OP_EMIT;
                valid  = 1'b1;
                last   = stat.last;
                if (stat.last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[design/timer_min_heap_queue.sv]
// Top level: timer queue kept as a binary min-heap ordered by expiry.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; func, id, timeout_ms and now_ms are sampled at that edge.
// Results: each result shows on the result ports for one cycle with valid
// high; last marks the final result of the transaction. The receiver cannot
// stall, so results leave back to back once delivery starts.
// A transaction runs lookup, any sift-down and sift-up levels, placing and
// the summary before its results are delivered. A refused add, adjust or
// fire skips the sift and goes straight to the summary. A tick pops due
// timers one at a time and re-sifts the node moved into the root after each
// pop.
// The sequential sift over the single-write heap memory sets the rate: one
// transaction at a time.
// After reset the position map is swept, one entry a cycle, over all ID_COUNT
// entries (1024 by default); busy stays high during the sweep. Clear only
// zeroes the heap size: map entries are checked against the heap on lookup.
`timescale 1ns / 1ps
`default_nettype none
module timer_min_heap_queue #(
    parameter int CAPACITY = tmhq_pkg::CAPACITY_DEF,
    parameter int ID_COUNT = tmhq_pkg::ID_COUNT_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [tmhq_pkg::FUNC_W-1:0]   func,
    input  wire logic [tmhq_pkg::ID_W-1:0]     id,
    input  wire logic [tmhq_pkg::TMO_W-1:0]    timeout_ms,
    input  wire logic [tmhq_pkg::TIME_W-1:0]   now_ms,
    output logic                               busy,
    output logic                               valid,
    output logic [tmhq_pkg::ID_W-1:0]          fired_id,
    output logic                               fired,
    output logic                               last,
    output logic [tmhq_pkg::STAT_W-1:0]        status,
    output logic                               next_valid,
    output logic [tmhq_pkg::WAIT_W-1:0]        next_wait_ms,
    output logic [tmhq_pkg::CNT_W-1:0]         pending_count
);
    import tmhq_pkg::*;

    cmd_t     cmd;
    dp_stat_t stat;

    tmhq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .valid (valid),
        .last  (last)
    );

    tmhq_dp #(
        .CAPACITY (CAPACITY),
        .ID_COUNT (ID_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .id            (id),
        .timeout_ms    (timeout_ms),
        .now_ms        (now_ms),
        .stat          (stat),
        .fired_id      (fired_id),
        .fired         (fired),
        .status        (status),
        .next_valid    (next_valid),
        .next_wait_ms  (next_wait_ms),
        .pending_count (pending_count)
    );

endmodule
`default_nettype wire

[design/tmhq_checker.sv]
// Port-level checker for the timer queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tmhq_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          busy,
    input wire logic                          valid,
    input wire logic [tmhq_pkg::ID_W-1:0]     fired_id,
    input wire logic                          fired,
    input wire logic                          last,
    input wire logic                          next_valid,
    input wire logic [tmhq_pkg::WAIT_W-1:0]   next_wait_ms,
    input wire logic [tmhq_pkg::CNT_W-1:0]    pending_count
);
    // Results only appear inside a transaction
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result outside a transaction");

    // Results of one transaction are contiguous
    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !last |=> valid) else $error("gap in result run");

    // The final result frees the block
    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |=> !busy) else $error("busy after final result");

    // An empty queue reports no wait and no count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !next_valid |-> next_wait_ms == '0 && pending_count == '0)
        else $error("empty queue summary inconsistent");

    // A result that fires nothing carries no id
    a_no_fire_id: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !fired |-> fired_id == '0) else $error("stray fired id");

endmodule

bind timer_min_heap_queue tmhq_checker u_tmhq_checker (.*);
`default_nettype wire

[test/tb_timer_min_heap_queue.sv]
// Testbench: timer min-heap queue checked against a behavioral heap predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_timer_min_heap_queue;
    import tmhq_pkg::*;

    localparam int HEAP_DEPTH = CAPACITY_DEF;
    localparam int N_IDS      = ID_COUNT_DEF;
    // Reserved function codes, ignored by the block
    localparam logic [FUNC_W-1:0] FUNC_RSVD5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0] op;
        logic [ID_W-1:0]   tid;
        logic [TMO_W-1:0]  tmo;
        logic [TIME_W-1:0] now;
    } cmd_item_t;

    typedef struct {
        logic [ID_W-1:0]   fid;
        logic              fired;
        logic              last;
        logic [STAT_W-1:0] status;
        logic              nv;
        logic [WAIT_W-1:0] wait_ms;
        logic [CNT_W-1:0]  count;
    } timer_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     id;
    logic [TMO_W-1:0]    timeout_ms;
    logic [TIME_W-1:0]   now_ms;
    logic                busy;
    logic                valid;
    logic [ID_W-1:0]     fired_id;
    logic                fired;
    logic                last;
    logic [STAT_W-1:0]   status;
    logic                next_valid;
    logic [WAIT_W-1:0]   next_wait_ms;
    logic [CNT_W-1:0]    pending_count;

    cmd_item_t     cmd_q[$];
    timer_result_t due_results[$];
    cmd_item_t     cur_cmd;
    int            gap_left;
    bit            failed;

    // Predictor state
    logic [ID_W-1:0]   heap_tid[HEAP_DEPTH];
    logic [TIME_W-1:0] heap_exp[HEAP_DEPTH];
    int                slot_of[N_IDS];
    bit                armed[N_IDS];
    int                heap_n;

    timer_min_heap_queue dut (
        .clk(clk), .rst_n(rst_n), .start(start), .func(func), .id(id),
        .timeout_ms(timeout_ms), .now_ms(now_ms), .busy(busy), .valid(valid),
        .fired_id(fired_id), .fired(fired), .last(last), .status(status),
        .next_valid(next_valid), .next_wait_ms(next_wait_ms),
        .pending_count(pending_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------- heap predictor ----------------
    function automatic bit sooner(int a, int b);
        logic [TIME_W-1:0] d;
        d = heap_exp[a] - heap_exp[b];
        return d[TIME_W-1];
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [ID_W-1:0]   t_id;
        logic [TIME_W-1:0] t_exp;
        t_id = heap_tid[a];
        t_exp = heap_exp[a];
        heap_tid[a] = heap_tid[b];
        heap_exp[a] = heap_exp[b];
        heap_tid[b] = t_id;
        heap_exp[b] = t_exp;
        slot_of[heap_tid[a]] = a;
        slot_of[heap_tid[b]] = b;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (sooner(p, i))
                break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic bit bubble_down(int s, int n);
        int i;
        int c;
        i = s;
        c = 2 * i + 1;
        while (c < n)
        begin
            if (c + 1 < n && sooner(c + 1, c))
                c++;
            if (sooner(i, c))
                break;
            swap_slots(i, c);
            i = c;
            c = 2 * i + 1;
        end
        return i > s;
    endfunction

    function automatic void reorder(int i);
        if (!bubble_down(i, heap_n))
            bubble_up(i);
    endfunction

    function automatic void drop_slot(int i);
        int n;
        n = heap_n - 1;
        if (i < n)
        begin
            swap_slots(i, n);
            if (!bubble_down(i, n))
                bubble_up(i);
        end
        armed[heap_tid[n]] = 1'b0;
        heap_n = n;
    endfunction

    // Apply one command and queue the results it should produce
    function automatic void predict_timer_step(cmd_item_t c);
        timer_result_t outs[$];
        timer_result_t r;
        logic [TIME_W-1:0] d;
        logic [WAIT_W-1:0] w;
        int i;
        bit pend;
        pend = armed[c.tid];
        r = '{default: '0};
        case (c.op)
            FUNC_ADD:
            begin
                if (pend)
                begin
                    i = slot_of[c.tid];
                    heap_exp[i] = c.now + TIME_W'(c.tmo);
                    reorder(i);
                end
                else if (heap_n >= HEAP_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    i = heap_n++;
                    heap_tid[i] = c.tid;
                    heap_exp[i] = c.now + TIME_W'(c.tmo);
                    slot_of[c.tid] = i;
                    armed[c.tid] = 1'b1;
                    bubble_up(i);
                end
                outs.insert(outs.size(), r);
            end
            FUNC_ADJ:
            begin
                if (!pend)
                    r.status = ST_NOT_PENDING;
                else
                begin
                    i = slot_of[c.tid];
                    heap_exp[i] = c.now + TIME_W'(c.tmo);
                    reorder(i);
                end
                outs.insert(outs.size(), r);
            end
            FUNC_FIRE:
            begin
                if (!pend)
                    r.status = ST_NOT_PENDING;
                else
                begin
                    drop_slot(slot_of[c.tid]);
                    r.fid = c.tid;
                    r.fired = 1'b1;
                end
                outs.insert(outs.size(), r);
            end
            FUNC_TICK:
            begin
                while (heap_n > 0 && outs.size() < MAX_RESULTS)
                begin
                    d = heap_exp[0] - c.now;
                    if (d != 0 && !d[TIME_W-1])
                        break;
                    r.fid = heap_tid[0];
                    r.fired = 1'b1;
                    drop_slot(0);
                    outs.insert(outs.size(), r);
                end
                // Nothing due: r still holds the all-zero result
                if (outs.size() == 0)
                    outs.insert(outs.size(), r);
            end
            FUNC_CLEAR:
            begin
                foreach (armed[k])
                    armed[k] = 1'b0;
                heap_n = 0;
                outs.insert(outs.size(), r);
            end
            default:
                outs.insert(outs.size(), r);
        endcase
        // Summary fields are the queue state after the whole step
        w = '0;
        if (heap_n > 0)
        begin
            d = heap_exp[0] - c.now;
            if (!d[TIME_W-1])
                w = (d > TIME_W'(WAIT_MAX)) ? WAIT_MAX : d[WAIT_W-1:0];
        end
        foreach (outs[k])
        begin
            outs[k].last = (k == outs.size() - 1);
            outs[k].nv = (heap_n > 0);
            outs[k].wait_ms = w;
            outs[k].count = CNT_W'(heap_n);
            due_results.insert(due_results.size(), outs[k]);
        end
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit go;
        if (!rst_n)
        begin
            start <= 1'b0;
            func <= '0;
            id <= '0;
            timeout_ms <= '0;
            now_ms <= '0;
            gap_left = 0;
        end
        else
        begin
            go = start;
            if (start && !busy)
            begin
                predict_timer_step(cur_cmd);
                go = 1'b0;
                gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(0, 7);
            end
            if (!go)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_q.size() > 0)
                begin
                    cur_cmd = cmd_q.pop_front();
                    func <= cur_cmd.op;
                    id <= cur_cmd.tid;
                    timeout_ms <= cur_cmd.tmo;
                    now_ms <= cur_cmd.now;
                    go = 1'b1;
                end
            end
            start <= go;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk)
    begin : monitor
        timer_result_t e;
        if (rst_n && valid)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with no transaction outstanding: fired_id=%0d", fired_id);
                failed = 1'b1;
            end
            else
            begin
                e = due_results.pop_front();
                if (fired_id !== e.fid)
                begin
                    $error("fired_id: expected %0d, got %0d", e.fid, fired_id);
                    failed = 1'b1;
                end
                if (fired !== e.fired)
                begin
                    $error("fired: expected %0d, got %0d", e.fired, fired);
                    failed = 1'b1;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    failed = 1'b1;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    failed = 1'b1;
                end
                if (next_valid !== e.nv)
                begin
                    $error("next_valid: expected %0d, got %0d", e.nv, next_valid);
                    failed = 1'b1;
                end
                if (next_wait_ms !== e.wait_ms)
                begin
                    $error("next_wait_ms: expected %0d, got %0d", e.wait_ms, next_wait_ms);
                    failed = 1'b1;
                end
                if (pending_count !== e.count)
                begin
                    $error("pending_count: expected %0d, got %0d", e.count, pending_count);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic void queue_cmd(logic [FUNC_W-1:0] op, logic [ID_W-1:0] tid,
                                      logic [TMO_W-1:0] tmo, logic [TIME_W-1:0] now);
        cmd_item_t c;
        c.op = op;
        c.tid = tid;
        c.tmo = tmo;
        c.now = now;
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    // One of the reserved function codes at random
    function automatic logic [FUNC_W-1:0] FUNC_FUNC_PICK();
        case ($urandom_range(0, 2))
            0: return FUNC_RSVD5;
            1: return FUNC_RSVD6;
            default: return FUNC_RSVD7;
        endcase
    endfunction

    // ---------------- stimulus ----------------
    initial
    begin
        logic [TIME_W-1:0] t;
        int pick;
        failed = 1'b0;
        heap_n = 0;
        foreach (armed[k])
            armed[k] = 1'b0;

        // Directed: empty queue, unknown ids, extremes, wrap, clear, reserved codes
        t = 32'hFFFF_FF00;
        queue_cmd(FUNC_TICK, 10'd0, 24'd0, t);
        queue_cmd(FUNC_FIRE, 10'd5, 24'd0, t);
        queue_cmd(FUNC_ADJ, 10'd5, 24'd9, t);
        queue_cmd(FUNC_ADD, 10'd0, 24'd0, t);
        queue_cmd(FUNC_ADD, 10'd1023, 24'hFF_FFFF, t);
        queue_cmd(FUNC_ADD, 10'd7, 24'd400, t);
        queue_cmd(FUNC_ADD, 10'd8, 24'd400, t);
        queue_cmd(FUNC_ADD, 10'd9, 24'd400, t);
        queue_cmd(FUNC_ADD, 10'd7, 24'd50, t);
        queue_cmd(FUNC_ADJ, 10'd8, 24'd10, t + 5);
        queue_cmd(FUNC_TICK, 10'd0, 24'd0, t);
        queue_cmd(FUNC_TICK, 10'd0, 24'd0, t + 60);
        queue_cmd(FUNC_FIRE, 10'd9, 24'd0, t + 61);
        queue_cmd(FUNC_TICK, 10'd0, 24'd0, t - 32'd5_000_000);
        queue_cmd(FUNC_TICK, 10'd0, 24'd0, 32'h8000_0000);
        queue_cmd(FUNC_RSVD5, 10'h2AA, 24'h55_5555, 32'hAAAA_AAAA);
        queue_cmd(FUNC_RSVD6, 10'h155, 24'hAA_AAAA, 32'h5555_5555);
        queue_cmd(FUNC_RSVD7, 10'd3, 24'd3, 32'd3);
        queue_cmd(FUNC_CLEAR, 10'd0, 24'd0, t);
        queue_cmd(FUNC_FIRE, 10'd1023, 24'd0, t);

        // Fill to capacity, overflow, then pop everything in one tick
        for (int k = 0; k < HEAP_DEPTH; k++)
            queue_cmd(FUNC_ADD, ID_W'(100 + k), 24'($urandom_range(0, 300)), t);
        queue_cmd(FUNC_ADD, 10'd999, 24'd1, t);
        queue_cmd(FUNC_ADD, 10'd100, 24'd2, t);
        queue_cmd(FUNC_TICK, 10'd0, 24'd0, t + 1000);

        // Random: advancing time over a small id pool, with some noise
        t = $urandom_range(0, 1) ? 32'hFFFF_F000 : $urandom;
        for (int n = 0; n < 165; n++)
        begin
            t += $urandom_range(0, 40);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_cmd(FUNC_ADD, ($urandom_range(0, 9) == 0) ? ID_W'($urandom)
                          : ID_W'($urandom_range(0, 47)),
                          ($urandom_range(0, 9) == 0) ? TMO_W'($urandom)
                          : TMO_W'($urandom_range(0, 200)), t);
            else if (pick < 55)
                queue_cmd(FUNC_ADJ, ID_W'($urandom_range(0, 47)),
                          TMO_W'($urandom_range(0, 200)), t);
            else if (pick < 68)
                queue_cmd(FUNC_FIRE, ID_W'($urandom_range(0, 47)), '0, t);
            else if (pick < 92)
                queue_cmd(FUNC_TICK, ID_W'($urandom), TMO_W'($urandom),
                          ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : t);
            else if (pick < 94)
                queue_cmd(FUNC_CLEAR, ID_W'($urandom), TMO_W'($urandom), t);
            else if (pick < 97)
                queue_cmd(FUNC_FUNC_PICK(), ID_W'($urandom), TMO_W'($urandom), $urandom);
            else
                queue_cmd(FUNC_TICK, '0, '0, t + TIME_W'($urandom_range(0, 5000)));
        end

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (cmd_q.size() == 0 && !start);
        wait (due_results.size() == 0);
        repeat (100) @(posedge clk);
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

[filelist.f]
design/tmhq_pkg.sv
design/tmhq_dp.sv
design/tmhq_ctrl.sv
design/timer_min_heap_queue.sv
design/tmhq_checker.sv
test/tb_timer_min_heap_queue.sv
